// ===== rtl/asgd_pkg.sv =====
// Shared types and constants of the swing and spin gesture detector.
// Holds item structs, register codes and reset values; no dependencies.
package asgd_pkg;

   // Default history geometry
   localparam int LOOKBACK_DEFAULT    = 20;
   localparam int SPIN_WINDOW_DEFAULT = 15;

   // Field widths
   localparam int ACCEL_W     = 16;
   localparam int DIST_W      = 35;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 35;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SWING_DIST_SQ_LIMIT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIN_DROP_LIMIT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWING_RELEASE_FRAMES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIN_RELEASE_FRAMES  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_START_FRAMES  = 3'd4;

   // Register reset values
   localparam logic [DIST_W-1:0] SWING_DIST_SQ_LIMIT_RST  = 35'd16777216;
   localparam logic [15:0]       SPIN_DROP_LIMIT_RST      = 16'd1638;
   localparam logic [7:0]        SWING_RELEASE_FRAMES_RST = 8'd6;
   localparam logic [7:0]        SPIN_RELEASE_FRAMES_RST  = 8'd8;
   localparam logic [7:0]        REPEAT_START_FRAMES_RST  = 8'd30;

   // Bound on the spin quiet count for repeated trigger pulses while spin is held
   localparam int REPEAT_PERIOD = 15;

   typedef struct packed {
      logic                      sample_ok;
      logic signed [ACCEL_W-1:0] accel_x;
      logic signed [ACCEL_W-1:0] accel_y;
      logic signed [ACCEL_W-1:0] accel_z;
   } req_item_type;

   typedef struct packed {
      logic swing_now;
      logic swing_held;
      logic spin_now;
      logic spin_held;
      logic trigger_pulse;
   } rsp_item_type;

   typedef struct packed {
      logic signed [ACCEL_W-1:0] x;
      logic signed [ACCEL_W-1:0] y;
      logic signed [ACCEL_W-1:0] z;
   } sample_type;

   // Classified item handed from front to back
   typedef struct packed {
      logic       sample_ok;
      logic       swing_en;
      logic       spin_en;
      sample_type sample;
   } cmd_type;

endpackage

// ===== rtl/asgd_fifo.sv =====
// Small register queue used between front and back and on the result side.
// Generic width and depth; no package dependencies.
module asgd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/asgd_front.sv =====
// Front end: accepts sample items, tracks the history fill level and marks
// each item for swing and spin evaluation. Uses asgd_pkg.
module asgd_front #(
   parameter int LOOKBACK    = asgd_pkg::LOOKBACK_DEFAULT,
   parameter int SPIN_WINDOW = asgd_pkg::SPIN_WINDOW_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  asgd_pkg::req_item_type req_data,
   input  logic                   q_full,
   output logic                   q_push,
   output asgd_pkg::cmd_type      q_cmd
);
   import asgd_pkg::*;

   localparam int HIST_DEPTH = (LOOKBACK + 1 > SPIN_WINDOW) ? LOOKBACK + 1 : SPIN_WINDOW;
   localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] count_next;
   logic             accept;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign q_push   = accept;

   // Fill level after this item; saturates at the history depth
   always_comb begin
      count_next = count_ff;
      if (req_data.sample_ok && (count_ff < CNT_W'(HIST_DEPTH))) begin
         count_next = count_ff + 1'b1;
      end
      count_in = accept ? count_next : count_ff;
   end

   // Classify the item
   always_comb begin
      q_cmd.sample_ok = req_data.sample_ok;
      q_cmd.swing_en  = req_data.sample_ok && (count_next >= CNT_W'(LOOKBACK + 1));
      q_cmd.spin_en   = (count_next >= CNT_W'(SPIN_WINDOW));
      q_cmd.sample.x  = req_data.accel_x;
      q_cmd.sample.y  = req_data.accel_y;
      q_cmd.sample.z  = req_data.accel_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/asgd_back.sv =====
// Back end: sample history memory, serial history walk, distance squares,
// latch counters, trigger and the configuration registers. Uses asgd_pkg.
module asgd_back #(
   parameter int LOOKBACK    = asgd_pkg::LOOKBACK_DEFAULT,
   parameter int SPIN_WINDOW = asgd_pkg::SPIN_WINDOW_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cmd_empty,
   output logic                                 cmd_pop,
   input  asgd_pkg::cmd_type                    cmd_data,
   input  logic                                 rsp_full,
   output logic                                 rsp_push,
   output asgd_pkg::rsp_item_type               rsp_item,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [asgd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [asgd_pkg::CSR_DATA_W-1:0]      csr_data
);
   import asgd_pkg::*;

   localparam int HIST_DEPTH = (LOOKBACK + 1 > SPIN_WINDOW) ? LOOKBACK + 1 : SPIN_WINDOW;
   localparam int AW         = $clog2(HIST_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DRAIN,
      S_MUL,
      S_UPDATE,
      S_EMIT
   } state_type;

   function automatic logic [15:0] sat_inc(input logic [15:0] c);
      return (c == 16'hFFFF) ? c : c + 16'd1;
   endfunction

   // Residue mod 15 by nibble folding (16 = 1 mod 15)
   function automatic logic mod15_is_zero(input logic [15:0] v);
      logic [5:0] s;
      logic [4:0] t;
      s = 6'(v[3:0]) + 6'(v[7:4]) + 6'(v[11:8]) + 6'(v[15:12]);
      t = 5'(s[5:4]) + 5'(s[3:0]);
      return (t == 5'd0) || (t == 5'd15);
   endfunction

   function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
      return (p == '0) ? AW'(HIST_DEPTH - 1) : p - 1'b1;
   endfunction

   // Configuration registers
   logic [DIST_W-1:0] dist_limit_ff, dist_limit_in;
   logic [15:0]       drop_limit_ff, drop_limit_in;
   logic [7:0]        swing_rel_ff, swing_rel_in;
   logic [7:0]        spin_rel_ff, spin_rel_in;
   logic [7:0]        repeat_start_ff, repeat_start_in;

   // Sequencer and walk
   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]     issue_age_ff, issue_age_in;
   logic [AW-1:0]     data_age_ff, data_age_in;
   logic              data_vld_ff, data_vld_in;
   sample_type        cur_ff, cur_in;
   sample_type        prev_ff, prev_in;
   logic signed [15:0] min_y_ff, min_y_in;
   logic [1:0]        mstep_ff, mstep_in;
   logic [31:0]       prod_ff, prod_in;
   logic [33:0]       acc_ff, acc_in;

   // Detector state
   logic              swing_flag_ff, swing_flag_in;
   logic              swing_latch_ff, swing_latch_in;
   logic [15:0]       swing_quiet_ff, swing_quiet_in;
   logic [15:0]       swing_lc_ff, swing_lc_in;
   logic              spin_now_ff, spin_now_in;
   logic              spin_latch_ff, spin_latch_in;
   logic [15:0]       spin_quiet_ff, spin_quiet_in;
   logic [15:0]       spin_hold_ff, spin_hold_in;

   // Memory
   sample_type        mem [HIST_DEPTH];
   sample_type        rd_data_ff;
   logic              mem_we;

   // Datapath intermediates
   logic signed [15:0] mul_a, mul_b;
   logic signed [16:0] mul_diff;
   logic signed [33:0] mul_sq;
   logic signed [16:0] spin_diff;
   logic               spin_hit;
   logic               swing_hit;
   logic               base_latch;
   logic [15:0]        base_quiet, base_hold;
   logic [15:0]        rep_gap;
   logic               trig;

   assign csr_ready = 1'b1;
   assign cmd_pop   = (state_ff == S_IDLE) && !cmd_empty;
   assign mem_we    = cmd_pop && cmd_data.sample_ok;
   assign rsp_push  = (state_ff == S_EMIT) && !rsp_full;

   // Configuration write decode
   always_comb begin
      dist_limit_in   = dist_limit_ff;
      drop_limit_in   = drop_limit_ff;
      swing_rel_in    = swing_rel_ff;
      spin_rel_in     = spin_rel_ff;
      repeat_start_in = repeat_start_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SWING_DIST_SQ_LIMIT:  dist_limit_in   = csr_data[DIST_W-1:0];
            CSR_SPIN_DROP_LIMIT:      drop_limit_in   = csr_data[15:0];
            CSR_SWING_RELEASE_FRAMES: swing_rel_in    = csr_data[7:0];
            CSR_SPIN_RELEASE_FRAMES:  spin_rel_in     = csr_data[7:0];
            CSR_REPEAT_START_FRAMES:  repeat_start_in = csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Squared difference of one axis per cycle
   always_comb begin
      case (mstep_ff)
         2'd0:    begin mul_a = cur_ff.x; mul_b = prev_ff.x; end
         2'd1:    begin mul_a = cur_ff.y; mul_b = prev_ff.y; end
         default: begin mul_a = cur_ff.z; mul_b = prev_ff.z; end
      endcase
      mul_diff = {mul_a[15], mul_a} - {mul_b[15], mul_b};
      mul_sq   = mul_diff * mul_diff;
   end

   // Spin peak: the running drop telescopes to y0 minus the window minimum
   always_comb begin
      spin_diff = {cur_ff.y[15], cur_ff.y} - {min_y_ff[15], min_y_ff};
      spin_hit  = cmd_ff.spin_en && !spin_diff[16] && (spin_diff[15:0] > drop_limit_ff);
      swing_hit = cmd_ff.swing_en && ({1'b0, acc_ff} >= dist_limit_ff);
   end

   // Spin state as seen at frame start; cleared unless swing_en is set
   always_comb begin
      base_latch = cmd_ff.swing_en ? spin_latch_ff : 1'b0;
      base_quiet = cmd_ff.swing_en ? spin_quiet_ff : 16'd0;
      base_hold  = cmd_ff.swing_en ? spin_hold_ff  : 16'd0;
   end

   // Trigger from the updated counters
   always_comb begin
      rep_gap = spin_hold_ff - {8'h00, repeat_start_ff};
      trig    = (swing_lc_ff == 16'd1) ||
                ((spin_hold_ff >= {8'h00, repeat_start_ff}) && mod15_is_zero(rep_gap) &&
                 (spin_quiet_ff < 16'(REPEAT_PERIOD)));
      rsp_item.swing_now     = swing_flag_ff;
      rsp_item.swing_held    = swing_latch_ff;
      rsp_item.spin_now      = spin_now_ff;
      rsp_item.spin_held     = spin_latch_ff;
      rsp_item.trigger_pulse = trig;
   end

   // Sequencer next state
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      wr_ptr_in      = wr_ptr_ff;
      rd_ptr_in      = rd_ptr_ff;
      issue_age_in   = issue_age_ff;
      data_age_in    = issue_age_ff;
      data_vld_in    = (state_ff == S_READ);
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      min_y_in       = min_y_ff;
      mstep_in       = mstep_ff;
      prod_in        = prod_ff;
      acc_in         = acc_ff;
      swing_flag_in  = swing_flag_ff;
      swing_latch_in = swing_latch_ff;
      swing_quiet_in = swing_quiet_ff;
      swing_lc_in    = swing_lc_ff;
      spin_now_in    = spin_now_ff;
      spin_latch_in  = spin_latch_ff;
      spin_quiet_in  = spin_quiet_ff;
      spin_hold_in   = spin_hold_ff;

      // Capture read data by age
      if (data_vld_ff) begin
         if (data_age_ff == '0) begin
            cur_in = rd_data_ff;
         end
         if (data_age_ff == AW'(1)) begin
            min_y_in = rd_data_ff.y;
         end else if ((data_age_ff > AW'(1)) && (data_age_ff <= AW'(SPIN_WINDOW - 1))) begin
            if (rd_data_ff.y < min_y_ff) begin
               min_y_in = rd_data_ff.y;
            end
         end
         if (data_age_ff == AW'(LOOKBACK)) begin
            prev_in = rd_data_ff;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_in       = cmd_data;
               issue_age_in = '0;
               if (cmd_data.sample_ok) begin
                  wr_ptr_in = (wr_ptr_ff == AW'(HIST_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
                  rd_ptr_in = wr_ptr_ff;
               end else begin
                  rd_ptr_in = ptr_dec(wr_ptr_ff);
               end
               state_in = S_READ;
            end
         end
         S_READ: begin
            rd_ptr_in    = ptr_dec(rd_ptr_ff);
            issue_age_in = issue_age_ff + 1'b1;
            if (issue_age_ff == AW'(HIST_DEPTH - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            mstep_in = 2'd0;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = mul_sq[31:0];
            acc_in   = (mstep_ff == 2'd0) ? '0 : acc_ff + {2'b00, prod_ff};
            mstep_in = mstep_ff + 1'b1;
            if (mstep_ff == 2'd3) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            swing_flag_in = swing_hit;
            if (cmd_ff.swing_en) begin
               swing_quiet_in = swing_hit ? 16'd0 : sat_inc(swing_quiet_ff);
               if (swing_latch_ff) begin
                  swing_latch_in = !(swing_quiet_in > {8'h00, swing_rel_ff});
               end else begin
                  swing_latch_in = swing_hit;
               end
               swing_lc_in = swing_latch_in ? sat_inc(swing_lc_ff) : 16'd0;
            end
            spin_now_in   = spin_hit;
            spin_quiet_in = spin_hit ? 16'd0 : sat_inc(base_quiet);
            if (base_latch) begin
               spin_latch_in = !(spin_quiet_in > {8'h00, spin_rel_ff});
            end else begin
               spin_latch_in = spin_hit;
            end
            spin_hold_in = spin_latch_in ? sat_inc(base_hold) : 16'd0;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_full) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer, detector state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         wr_ptr_ff       <= '0;
         data_vld_ff     <= 1'b0;
         swing_flag_ff   <= 1'b0;
         swing_latch_ff  <= 1'b0;
         swing_quiet_ff  <= '0;
         swing_lc_ff     <= '0;
         spin_now_ff     <= 1'b0;
         spin_latch_ff   <= 1'b0;
         spin_quiet_ff   <= '0;
         spin_hold_ff    <= '0;
         dist_limit_ff   <= SWING_DIST_SQ_LIMIT_RST;
         drop_limit_ff   <= SPIN_DROP_LIMIT_RST;
         swing_rel_ff    <= SWING_RELEASE_FRAMES_RST;
         spin_rel_ff     <= SPIN_RELEASE_FRAMES_RST;
         repeat_start_ff <= REPEAT_START_FRAMES_RST;
      end else begin
         state_ff        <= state_in;
         wr_ptr_ff       <= wr_ptr_in;
         data_vld_ff     <= data_vld_in;
         swing_flag_ff   <= swing_flag_in;
         swing_latch_ff  <= swing_latch_in;
         swing_quiet_ff  <= swing_quiet_in;
         swing_lc_ff     <= swing_lc_in;
         spin_now_ff     <= spin_now_in;
         spin_latch_ff   <= spin_latch_in;
         spin_quiet_ff   <= spin_quiet_in;
         spin_hold_ff    <= spin_hold_in;
         dist_limit_ff   <= dist_limit_in;
         drop_limit_ff   <= drop_limit_in;
         swing_rel_ff    <= swing_rel_in;
         spin_rel_ff     <= spin_rel_in;
         repeat_start_ff <= repeat_start_in;
         cmd_ff          <= cmd_in;
         rd_ptr_ff       <= rd_ptr_in;
         issue_age_ff    <= issue_age_in;
         data_age_ff     <= data_age_in;
         cur_ff          <= cur_in;
         prev_ff         <= prev_in;
         min_y_ff        <= min_y_in;
         mstep_ff        <= mstep_in;
         prod_ff         <= prod_in;
         acc_ff          <= acc_in;
      end
   end

   // History memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_ptr_ff] <= cmd_data.sample;
      end
      rd_data_ff <= mem[rd_ptr_ff];
   end

`ifndef SYNTHESIS
   a_swing_count_tracks_latch: assert property (@(posedge clock) disable iff (reset)
      swing_latch_ff == (swing_lc_ff != 16'd0))
      else $error("swing latch count out of step with latch");

   a_spin_hold_tracks_latch: assert property (@(posedge clock) disable iff (reset)
      spin_latch_ff == (spin_hold_ff != 16'd0))
      else $error("spin hold count out of step with latch");

   a_emit_returns_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> (state_ff == S_IDLE))
      else $error("sequencer did not return to idle after a result");

   a_spin_now_clears_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) && spin_now_ff |-> (spin_quiet_ff == 16'd0))
      else $error("spin quiet count not cleared on a spin frame");

   a_pop_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (state_ff == S_READ))
      else $error("item taken without starting the history walk");
`endif

endmodule

// ===== rtl/accel_swing_gesture_detect.sv =====
// Top level of the accelerometer swing and spin gesture detector.
// Instantiates asgd_front, two asgd_fifo queues and asgd_back; uses asgd_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  req     | in        | req_push / req_full  | req_data  (req_item_type)
//  rsp     | out       | rsp_pop / rsp_empty  | rsp_data  (rsp_item_type)
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// Each item walks the history memory one entry a cycle through its single
// read port, then three axis squares share one multiplier.
// Two items queue ahead of the back end and two results queue behind it.
// Reset is synchronous; the history memory needs no clearing pass.
// A stalled result side only holds the back end once the result queue fills.
module accel_swing_gesture_detect #(
   parameter int LOOKBACK    = asgd_pkg::LOOKBACK_DEFAULT,
   parameter int SPIN_WINDOW = asgd_pkg::SPIN_WINDOW_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  asgd_pkg::req_item_type          req_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output asgd_pkg::rsp_item_type          rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [asgd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [asgd_pkg::CSR_DATA_W-1:0] csr_data
);
   import asgd_pkg::*;

   localparam int QUEUE_DEPTH = 2;

   cmd_type      front_cmd, back_cmd;
   logic         front_push, cmdq_full, cmdq_empty, cmd_pop;
   rsp_item_type back_item;
   logic         rsp_push, rspq_full;

   // Front end: accept and classify
   asgd_front #(
      .LOOKBACK    (LOOKBACK),
      .SPIN_WINDOW (SPIN_WINDOW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_full   (cmdq_full),
      .q_push   (front_push),
      .q_cmd    (front_cmd)
   );

   // Queue between front and back
   asgd_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_cmd),
      .full      (cmdq_full),
      .pop       (cmd_pop),
      .pop_data  (back_cmd),
      .empty     (cmdq_empty)
   );

   // Back end: history walk and detectors
   asgd_back #(
      .LOOKBACK    (LOOKBACK),
      .SPIN_WINDOW (SPIN_WINDOW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmdq_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (back_cmd),
      .rsp_full  (rspq_full),
      .rsp_push  (rsp_push),
      .rsp_item  (back_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Result queue
   asgd_fifo #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_item),
      .full      (rspq_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule
